>>> hw/rtl/ffa_pkg.sv
`timescale 1ns / 1ps
package ffa_pkg;

  localparam int AW = 32;
  localparam logic [AW-1:0] DEFAULT_HEAP = 32'h0400_0000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [AW-1:0] addr_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INSERT,
    OP_SORT,
    OP_UNSORT,
    OP_FLAG,
    OP_EVAL,
    OP_DROP,
    OP_MERGE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     parity;
    addr_t    size;
    addr_t    amask;
    addr_t    value;
  } ctl_t;

  typedef struct packed {
    logic  v;
    logic  fl;
    addr_t start;
    addr_t len;
  } cell_t;

endpackage

>>> hw/rtl/ffa_cell.sv
`timescale 1ns / 1ps
module ffa_cell #(
  parameter int IDX   = 0,
  parameter bit LAST  = 1'b0,
  parameter int TAG_W = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ffa_pkg::ctl_t        ctl_i,
  input  ffa_pkg::cell_t       left_i,
  input  logic [TAG_W-1:0]     left_tag_i,
  input  ffa_pkg::cell_t       right_i,
  input  logic [TAG_W-1:0]     right_tag_i,
  input  logic                 fit_pre_i,
  input  logic                 fl_pre_i,
  output ffa_pkg::cell_t       cell_o,
  output logic [TAG_W-1:0]     tag_o,
  output logic                 fit_o,
  output ffa_pkg::addr_t       grant_o
);
  import ffa_pkg::*;

  localparam bit ODD = ((IDX % 2) == 1);
  localparam bit FIRST = (IDX == 0);
  localparam cell_t RST_CELL = '{
    v: FIRST, fl: 1'b0, start: '0, len: (FIRST ? DEFAULT_HEAP : '0)
  };

  cell_t            cell_q, cell_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  addr_t            pad;
  logic [AW:0]      need;
  logic             hit;
  logic             is_left, is_right, sw_r, sw_l;
  logic [AW:0]      key_me, key_l, key_r;

  always_comb begin
    pad   = (~cell_q.start + addr_t'(1)) & ctl_i.amask;
    need  = {1'b0, pad} + {1'b0, ctl_i.size};
    fit_o = cell_q.v && (need <= {1'b0, cell_q.len});
    hit   = fit_o && !fit_pre_i;
    grant_o = hit ? (cell_q.start + pad) : '0;

    if (ctl_i.op == OP_UNSORT) begin
      key_me = (AW+1)'(tag_q);
      key_l  = (AW+1)'(left_tag_i);
      key_r  = (AW+1)'(right_tag_i);
    end else begin
      key_me = {~cell_q.v, cell_q.start};
      key_l  = {~left_i.v, left_i.start};
      key_r  = {~right_i.v, right_i.start};
    end
    is_left  = (ODD == ctl_i.parity) && !LAST;
    is_right = (ODD != ctl_i.parity) && !FIRST;
    sw_r     = is_left && (key_me > key_r);
    sw_l     = is_right && (key_l > key_me);

    cell_d = cell_q;
    tag_d  = tag_q;
    case (ctl_i.op)
      OP_LOAD: begin
        cell_d.v     = FIRST && (ctl_i.value != '0);
        cell_d.fl    = 1'b0;
        cell_d.start = '0;
        cell_d.len   = FIRST ? ctl_i.value : '0;
      end
      OP_INSERT: begin
        tag_d = TAG_W'(IDX);
        if (LAST) begin
          cell_d.v     = 1'b1;
          cell_d.fl    = 1'b0;
          cell_d.start = ctl_i.value;
          cell_d.len   = ctl_i.size;
        end
      end
      OP_SORT, OP_UNSORT: begin
        if (sw_r) begin
          cell_d = right_i;
          tag_d  = right_tag_i;
        end else if (sw_l) begin
          cell_d = left_i;
          tag_d  = left_tag_i;
        end
        // refused range comes back to the last cell and is dropped there
        if (LAST && (ctl_i.op == OP_UNSORT) && (tag_d == TAG_W'(IDX))) begin
          cell_d.v = 1'b0;
        end
      end
      OP_FLAG: begin
        cell_d.fl = !FIRST && cell_q.v && left_i.v &&
                    ((left_i.start + left_i.len) == cell_q.start);
      end
      OP_EVAL: begin
        if (hit) begin
          cell_d.start = cell_q.start + need[AW-1:0];
          cell_d.len   = cell_q.len - need[AW-1:0];
          cell_d.fl    = (need[AW-1:0] == cell_q.len);
        end
      end
      OP_DROP, OP_MERGE: begin
        if (fl_pre_i || cell_q.fl) begin
          cell_d = right_i;
          tag_d  = right_tag_i;
        end else if ((ctl_i.op == OP_MERGE) && right_i.fl) begin
          cell_d.len = cell_q.len + right_i.len;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= RST_CELL;
      tag_q  <= '0;
    end else begin
      cell_q <= cell_d;
      tag_q  <= tag_d;
    end
  end

  assign cell_o = cell_q;
  assign tag_o  = tag_q;

endmodule

>>> hw/rtl/first_fit_aligned_allocator.sv
`timescale 1ns / 1ps
// channel   direction  handshake                   payload
// in        input      in_valid_i / in_ready_o     cmd, req_size, align_log2, release_offset
// out       output     out_valid_o / out_ready_i   status, grant_offset, bytes_in_use, free_count
// cfg       input      cfg_valid_i / cfg_ready_o   cfg_heap_size
//
// allocate: fit test and first-fit update in every cell, then drop shift, then
// output load; the drop shift is skipped when nothing fits
// release: insert, the odd-even sort pass over the N + 1 cells, N = FREE_ENTRIES,
// flag, check, then merge steps until no pair is flagged, then output load; a
// release refused as full takes a further pass that restores the table order
// one transaction in flight; a finished result waits in the output register,
// input is taken again once the result is loaded there and no cfg write waits
module first_fit_aligned_allocator #(
  parameter int FREE_ENTRIES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_i,
  input  logic [31:0]          req_size_i,
  input  logic [4:0]           align_log2_i,
  input  logic [31:0]          release_offset_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [31:0]          grant_offset_o,
  output logic [31:0]          bytes_in_use_o,
  output logic [4:0]           free_count_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [31:0]          cfg_heap_size_i
);
  import ffa_pkg::*;

  localparam int NC    = FREE_ENTRIES + 1;
  localparam int TAG_W = $clog2(NC);
  localparam int RND_W = $clog2(NC);
  localparam int CNT_W = $clog2(FREE_ENTRIES + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_AEVAL, S_ADROP, S_RINS, S_RSORT, S_RFLAG, S_RCHECK,
    S_RMERGE, S_RUNSORT, S_RESP
  } state_e;

  state_e           state_q;
  logic [RND_W-1:0] rnd_q;
  logic [CNT_W-1:0] cnt_q, out_cnt_q;
  addr_t            used_q, size_q, off_q, grant_q;
  logic [4:0]       lg_q;
  logic [1:0]       status_q, out_status_q;
  logic             out_valid_q;
  addr_t            out_grant_q, out_used_q;

  ctl_t             ctl;
  cell_t            cells [NC];
  logic [TAG_W-1:0] tags  [NC];
  addr_t            grants[NC];
  logic [NC-1:0]    fit, fl, fit_pre, fl_pre;
  logic             any_fit, any_fl, in_acc, cfg_acc;
  addr_t            grant_or;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    ctl.op     = OP_NOP;
    ctl.parity = rnd_q[0];
    ctl.size   = size_q;
    ctl.amask  = AW'(((AW+1)'(1) << lg_q) - (AW+1)'(1));
    ctl.value  = off_q;
    case (state_q)
      S_IDLE: begin
        if (cfg_acc) begin
          ctl.op    = OP_LOAD;
          ctl.value = cfg_heap_size_i;
        end
      end
      S_AEVAL:   ctl.op = OP_EVAL;
      S_ADROP:   ctl.op = OP_DROP;
      S_RINS:    ctl.op = OP_INSERT;
      S_RSORT:   ctl.op = OP_SORT;
      S_RFLAG:   ctl.op = OP_FLAG;
      S_RMERGE:  ctl.op = OP_MERGE;
      S_RUNSORT: ctl.op = OP_UNSORT;
      default:   ctl.op = OP_NOP;
    endcase
  end

  always_comb begin
    fit_pre[0] = 1'b0;
    fl_pre[0]  = 1'b0;
    grant_or   = grants[0];
    for (int i = 0; i < NC; i++) begin
      fl[i] = cells[i].fl;
    end
    for (int i = 1; i < NC; i++) begin
      fit_pre[i] = fit_pre[i-1] | fit[i-1];
      fl_pre[i]  = fl_pre[i-1] | fl[i-1];
      grant_or   = grant_or | grants[i];
    end
    any_fit = fit_pre[NC-1] | fit[NC-1];
    any_fl  = fl_pre[NC-1] | fl[NC-1];
  end

  for (genvar g = 0; g < NC; g++) begin : g_cell
    cell_t            left_c, right_c;
    logic [TAG_W-1:0] left_t, right_t;
    if (g == 0) begin : g_first
      assign left_c = '0;
      assign left_t = '0;
    end else begin : g_mid_l
      assign left_c = cells[g-1];
      assign left_t = tags[g-1];
    end
    if (g == NC - 1) begin : g_last
      assign right_c = '0;
      assign right_t = '0;
    end else begin : g_mid_r
      assign right_c = cells[g+1];
      assign right_t = tags[g+1];
    end
    ffa_cell #(
      .IDX   (g),
      .LAST  (g == NC - 1),
      .TAG_W (TAG_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .left_i      (left_c),
      .left_tag_i  (left_t),
      .right_i     (right_c),
      .right_tag_i (right_t),
      .fit_pre_i   (fit_pre[g]),
      .fl_pre_i    (fl_pre[g]),
      .cell_o      (cells[g]),
      .tag_o       (tags[g]),
      .fit_o       (fit[g]),
      .grant_o     (grants[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rnd_q        <= '0;
      cnt_q        <= CNT_W'(1);
      used_q       <= '0;
      size_q       <= '0;
      off_q        <= '0;
      lg_q         <= '0;
      grant_q      <= '0;
      status_q     <= ST_OK;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_grant_q  <= '0;
      out_used_q   <= '0;
      out_cnt_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cfg_acc) begin
            cnt_q <= (cfg_heap_size_i != '0) ? CNT_W'(1) : '0;
          end
          if (in_acc) begin
            size_q  <= req_size_i;
            off_q   <= release_offset_i;
            lg_q    <= align_log2_i;
            state_q <= cmd_i ? S_RINS : S_AEVAL;
          end
        end
        S_AEVAL: begin
          if (any_fit) begin
            grant_q  <= grant_or;
            used_q   <= used_q + size_q;
            status_q <= ST_OK;
            state_q  <= S_ADROP;
          end else begin
            grant_q  <= '0;
            status_q <= ST_NOFIT;
            state_q  <= S_RESP;
          end
        end
        S_ADROP: begin
          if (any_fl) begin
            cnt_q <= cnt_q - CNT_W'(1);
          end
          state_q <= S_RESP;
        end
        S_RINS: begin
          rnd_q   <= '0;
          state_q <= S_RSORT;
        end
        S_RSORT: begin
          if (rnd_q == RND_W'(FREE_ENTRIES)) begin
            state_q <= S_RFLAG;
          end else begin
            rnd_q <= rnd_q + RND_W'(1);
          end
        end
        S_RFLAG: begin
          state_q <= S_RCHECK;
        end
        S_RCHECK: begin
          grant_q <= '0;
          rnd_q   <= '0;
          if ((cnt_q == CNT_W'(FREE_ENTRIES)) && !any_fl) begin
            state_q <= S_RUNSORT;
          end else begin
            cnt_q   <= cnt_q + CNT_W'(1);
            state_q <= S_RMERGE;
          end
        end
        S_RMERGE: begin
          if (any_fl) begin
            cnt_q <= cnt_q - CNT_W'(1);
          end else begin
            used_q   <= used_q - size_q;
            status_q <= ST_OK;
            state_q  <= S_RESP;
          end
        end
        S_RUNSORT: begin
          if (rnd_q == RND_W'(FREE_ENTRIES)) begin
            status_q <= ST_FULL;
            state_q  <= S_RESP;
          end else begin
            rnd_q <= rnd_q + RND_W'(1);
          end
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_grant_q  <= grant_q;
            out_used_q   <= used_q;
            out_cnt_q    <= cnt_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign grant_offset_o = out_grant_q;
  assign bytes_in_use_o = out_used_q;
  assign free_count_o   = 5'(out_cnt_q);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_RMERGE) |-> cnt_q <= CNT_W'(FREE_ENTRIES))
    else $error("free range count above table depth");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == ST_FULL) |-> out_cnt_q == CNT_W'(FREE_ENTRIES))
    else $error("table full reported with room left");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != ST_OK) |-> out_grant_q == '0)
    else $error("grant offset set on failed transaction");

  a_drop_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADROP) |-> $onehot0(fl))
    else $error("more than one range marked for drop");

endmodule
